// ===== design/dnp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnp_pkg: shared types and constants for the domain name text parser
// Item formats, character classes, parse phases and outcome codes.
// ----------------------------------------------------------------------------
package dnp_pkg;

  localparam int MAX_LABEL_CHARS = 63;
  localparam int MAX_LABELS      = 255;
  localparam int QUEUE_DEPTH     = 4;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_out;
    logic       label_end;
    logic [5:0] label_length;
    logic       root_appended;
    logic       name_done;
    logic [3:0] error_code;
  } out_item_t;

  typedef enum logic [2:0] {
    CC_QUOTE,
    CC_BSLASH,
    CC_DOT,
    CC_WHITE,
    CC_PLAIN,
    CC_OTHER
  } char_class_t;

  typedef struct packed {
    logic [7:0]  char_in;
    logic        last;
    char_class_t cls;
  } cls_item_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_BODY,
    PH_CLOSED,
    PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_HALT,
    ACT_CLOSE,
    ACT_BYTE,
    ACT_LABEL,
    ACT_ESC
  } action_t;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_OPEN_QUOTE  = 4'd1;
  localparam logic [3:0] ERR_EMPTY_LABEL = 4'd2;
  localparam logic [3:0] ERR_MANY_LABELS = 4'd3;
  localparam logic [3:0] ERR_DANGLE_ESC  = 4'd4;
  localparam logic [3:0] ERR_LABEL_LONG  = 4'd5;
  localparam logic [3:0] ERR_NEED_QUOTES = 4'd6;
  localparam logic [3:0] ERR_NO_DOT      = 4'd7;
  localparam logic [3:0] ERR_EMPTY_NAME  = 4'd8;
  localparam logic [3:0] ERR_TRAILING    = 4'd9;

endpackage
`default_nettype wire

// ===== design/dnp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnp_front: input stage of the domain name text parser
// Registers each accepted character together with its character class.
// ----------------------------------------------------------------------------
module dnp_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  dnp_pkg::in_item_t   in_item,
  output logic                f_valid,
  input  wire                 f_ready,
  output dnp_pkg::cls_item_t  f_item
);
  import dnp_pkg::*;

  logic        f_valid_r;
  cls_item_t   f_item_r;
  char_class_t cls;
  logic [7:0]  c;

  always_comb begin
    c = in_item.char_in;
    if (c == 8'h22) begin
      cls = CC_QUOTE;
    end else if (c == 8'h5C) begin
      cls = CC_BSLASH;
    end else if (c == 8'h2E) begin
      cls = CC_DOT;
    end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
      cls = CC_WHITE;
    end else if (c == 8'h2D || c == 8'h5F || c == 8'h2A ||
                 (c >= 8'h30 && c <= 8'h39) ||
                 (c >= 8'h41 && c <= 8'h5A) ||
                 (c >= 8'h61 && c <= 8'h7A)) begin
      cls = CC_PLAIN;
    end else begin
      cls = CC_OTHER;
    end
  end

  assign in_ready = !f_valid_r || f_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_ready) begin
      f_valid_r <= in_valid;
    end
  end

  // hold payload while the stage waits on the queue
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_item_r.char_in <= in_item.char_in;
      f_item_r.last    <= in_item.last;
      f_item_r.cls     <= cls;
    end
  end

  assign f_valid = f_valid_r;
  assign f_item  = f_item_r;

endmodule
`default_nettype wire

// ===== design/dnp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnp_queue: short queue between classifier and parse engine
// Register-based FIFO; lets the front and back stall independently.
// ----------------------------------------------------------------------------
module dnp_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push_valid,
  output logic                push_ready,
  input  dnp_pkg::cls_item_t  push_item,
  output logic                pop_valid,
  input  wire                 pop_ready,
  output dnp_pkg::cls_item_t  pop_item
);
  import dnp_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cls_item_t       slot_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CntW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== design/dnp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnp_back: parse engine of the domain name text parser
// Tracks quoting, escapes and label counts; registers one result per item.
// ----------------------------------------------------------------------------
module dnp_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_valid,
  output logic                q_ready,
  input  dnp_pkg::cls_item_t  q_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output dnp_pkg::out_item_t  out_item
);
  import dnp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic       quoted_r, quoted_nxt;
  logic       esc_r, esc_nxt;
  logic [5:0] lchars_r, lchars_nxt;
  logic [8:0] lcount_r, lcount_nxt;
  logic       prev_empty_r, prev_empty_nxt;
  logic [3:0] pend_r, pend_nxt;

  logic       out_valid_r;
  out_item_t  out_item_r, res;
  logic       take;

  action_t    act;
  logic [3:0] halt_code;
  logic [3:0] cc;
  logic       opened, q_eff;
  phase_t     ph_eff;
  logic       full_label;
  logic [3:0] fin_code;

  assign take    = q_valid && (!out_valid_r || out_ready);
  assign q_ready = take;

  assign cc = (lchars_r != '0) ? ERR_NO_DOT :
              (lcount_r == '0) ? ERR_EMPTY_NAME : ERR_NONE;
  assign full_label = (lchars_r >= 6'(MAX_LABEL_CHARS));

  // classify what this character does to the parse
  always_comb begin
    opened    = (phase_r == PH_START) && (q_item.cls == CC_QUOTE);
    q_eff     = quoted_r || opened;
    ph_eff    = (phase_r == PH_START) ? PH_BODY : phase_r;
    act       = ACT_NONE;
    halt_code = ERR_NONE;
    if (ph_eff == PH_HALT) begin
      act = ACT_NONE;
    end else if (ph_eff == PH_CLOSED) begin
      act       = ACT_HALT;
      halt_code = (pend_r != ERR_NONE) ? pend_r : ERR_TRAILING;
    end else if (opened) begin
      act = ACT_NONE;
    end else if (esc_r) begin
      act = ACT_BYTE;
    end else if (!q_eff && q_item.cls == CC_WHITE) begin
      act       = ACT_HALT;
      halt_code = (cc != ERR_NONE) ? cc : ERR_TRAILING;
    end else if (q_item.cls == CC_DOT) begin
      if (prev_empty_r || (lchars_r == '0 && lcount_r != '0)) begin
        act       = ACT_HALT;
        halt_code = ERR_EMPTY_LABEL;
      end else if (lcount_r >= 9'(MAX_LABELS)) begin
        act       = ACT_HALT;
        halt_code = ERR_MANY_LABELS;
      end else begin
        act = ACT_LABEL;
      end
    end else if (q_item.cls == CC_BSLASH) begin
      act = ACT_ESC;
    end else if (q_eff && q_item.cls == CC_QUOTE) begin
      act = ACT_CLOSE;
    end else if (!q_eff && q_item.cls != CC_PLAIN) begin
      act       = ACT_HALT;
      halt_code = ERR_NEED_QUOTES;
    end else begin
      act = ACT_BYTE;
    end
    if (act == ACT_BYTE && full_label) begin
      act       = ACT_HALT;
      halt_code = ERR_LABEL_LONG;
    end
  end

  // next state
  always_comb begin
    phase_nxt      = ph_eff;
    quoted_nxt     = q_eff;
    esc_nxt        = esc_r;
    lchars_nxt     = lchars_r;
    lcount_nxt     = lcount_r;
    prev_empty_nxt = prev_empty_r;
    pend_nxt       = pend_r;
    case (act)
      ACT_HALT: begin
        phase_nxt = PH_HALT;
        pend_nxt  = halt_code;
      end
      ACT_CLOSE: begin
        phase_nxt = PH_CLOSED;
        pend_nxt  = cc;
      end
      ACT_BYTE: begin
        esc_nxt    = 1'b0;
        lchars_nxt = lchars_r + 6'd1;
      end
      ACT_LABEL: begin
        prev_empty_nxt = (lchars_r == '0);
        lchars_nxt     = '0;
        lcount_nxt     = lcount_r + 9'd1;
      end
      ACT_ESC: begin
        esc_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result of this character
  always_comb begin
    if (phase_nxt == PH_HALT || phase_nxt == PH_CLOSED) begin
      fin_code = pend_nxt;
    end else if (esc_nxt) begin
      fin_code = ERR_DANGLE_ESC;
    end else if (quoted_nxt) begin
      fin_code = ERR_OPEN_QUOTE;
    end else if (lchars_nxt != '0) begin
      fin_code = ERR_NO_DOT;
    end else if (lcount_nxt == '0) begin
      fin_code = ERR_EMPTY_NAME;
    end else begin
      fin_code = ERR_NONE;
    end
    res = '0;
    case (act)
      ACT_BYTE: begin
        res.byte_valid = 1'b1;
        res.byte_out   = q_item.char_in;
      end
      ACT_LABEL: begin
        res.label_end    = 1'b1;
        res.label_length = lchars_r;
      end
      default: begin
      end
    endcase
    if (q_item.last) begin
      res.error_code = fin_code;
      if (fin_code == ERR_NONE) begin
        res.name_done     = 1'b1;
        res.root_appended = !prev_empty_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      quoted_r     <= 1'b0;
      esc_r        <= 1'b0;
      lchars_r     <= '0;
      lcount_r     <= '0;
      prev_empty_r <= 1'b0;
      pend_r       <= ERR_NONE;
    end else if (take) begin
      if (q_item.last) begin
        // restart for the next name
        phase_r      <= PH_START;
        quoted_r     <= 1'b0;
        esc_r        <= 1'b0;
        lchars_r     <= '0;
        lcount_r     <= '0;
        prev_empty_r <= 1'b0;
        pend_r       <= ERR_NONE;
      end else begin
        phase_r      <= phase_nxt;
        quoted_r     <= quoted_nxt;
        esc_r        <= esc_nxt;
        lchars_r     <= lchars_nxt;
        lcount_r     <= lcount_nxt;
        prev_empty_r <= prev_empty_nxt;
        pend_r       <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ===== design/dns_name_text_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dns_name_text_parser: domain name presentation-format parser
// Takes a textual domain name one character per transfer on the in_ channel,
// with in_item.last on the final character, and returns one result per
// character on the out_ channel: label bytes with escapes removed, label ends
// with their length, and on the last character the outcome for the name
// (name_done, root_appended, error_code). After an error the remaining
// characters of the name give empty results until last.
// A character passes through the classifier register, a queue slot and the
// result register before it shows on the out_ channel. Throughput is one
// character per cycle while out_ready stays high; the parse state updates
// once per character in the back engine. The result register holds while
// out_ready is low and the queue keeps taking characters until it fills,
// then in_ready drops.
// Synchronous reset clears all parse state, the queue and both valid flags;
// the block starts at the beginning of a name.
// ----------------------------------------------------------------------------
module dns_name_text_parser (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  dnp_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output dnp_pkg::out_item_t  out_item
);
  import dnp_pkg::*;

  logic      f_valid, f_ready;
  cls_item_t f_item;
  logic      q_valid, q_ready;
  cls_item_t q_item;

  dnp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_item   (f_item)
  );

  dnp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  dnp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
